// ----- src/bpq_pkg.sv -----
package bpq_pkg;

	localparam int unsigned CoordW = 32;
	localparam int unsigned RelW   = 33;
	localparam int unsigned QW     = 30;
	localparam int unsigned SliceW = 10;
	localparam int unsigned ColorW = 24;
	localparam int unsigned BoxW   = 35;

	// Register indexes on the configuration port.
	localparam logic [3:0] RegOriginX = 4'h0;
	localparam logic [3:0] RegOriginY = 4'h4;
	localparam logic [3:0] RegOriginZ = 4'h8;

	// Result kinds.
	localparam logic KindHeader = 1'b0;
	localparam logic KindPoint  = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic store;     // write the accepted point and update the box
		logic load_pt;   // start the dividers for the point at rd_idx
		logic step;      // one quotient bit on every axis
		logic clear_box; // reset the box after the run
		logic emit_hdr;  // load the header into the output register
		logic emit_pt;   // load the point result into the output register
		logic last;      // run_last for the result being loaded
	} bpq_cmd_t;

	// Status from the datapath.
	typedef struct packed {
		logic out_busy;
	} bpq_sts_t;

endpackage

// ----- src/bpq_ram.sv -----
module bpq_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 32,
	localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem_q [Depth];

	// Single write port, registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/bpq_datapath.sv -----
module bpq_datapath #(
	parameter int unsigned BatchPoints = 32,
	parameter int unsigned IdxW = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bpq_pkg::bpq_cmd_t         cmd,
	output bpq_pkg::bpq_sts_t         sts,
	input  logic [IdxW-1:0]           wr_idx,
	input  logic [IdxW-1:0]           rd_idx,
	input  logic [95:0]               pt_xyz,
	input  logic [23:0]               pt_rgb,
	input  logic [95:0]               origin,
	input  logic                      m_tready,
	output logic                      m_tvalid,
	output logic [1:0]                m_tuser,
	output logic [319:0]              m_tdata
);
	import bpq_pkg::*;

	// Per-axis result selection.
	localparam logic [1:0] ModeDiv  = 2'd0;
	localparam logic [1:0] ModeZero = 2'd1;
	localparam logic [1:0] ModeMax  = 2'd2;

	logic [95:0]       xyz_rd;
	logic [ColorW-1:0] rgb_rd;
	logic signed [BoxW-1:0] min_q [3];
	logic signed [BoxW-1:0] max_q [3];
	logic [BoxW-1:0] rem_q [3];
	logic [BoxW-1:0] size_q [3];
	logic [QW-1:0]   quo_q [3];
	logic [1:0]      mode_q [3]; // divide, force zero or force max
	logic [ColorW-1:0] col_q;
	logic            valid_q;
	logic [1:0]      user_q;
	logic [319:0]    data_q;
	logic [89:0]     qf;
	logic [319:0]    hdr_d;

	bpq_ram #(.Width(96), .Depth(BatchPoints)) u_xyz (
		.clk(clk), .we(cmd.store), .waddr(wr_idx), .wdata(pt_xyz),
		.raddr(rd_idx), .rdata(xyz_rd));
	bpq_ram #(.Width(ColorW), .Depth(BatchPoints)) u_rgb (
		.clk(clk), .we(cmd.store), .waddr(wr_idx), .wdata(pt_rgb),
		.raddr(rd_idx), .rdata(rgb_rd));

	// Running bounding box of the relative coordinates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				min_q[a] <= BoxW'(36'sh0FFFFFFFF);
				max_q[a] <= -BoxW'(36'sh100000000);
			end
		end else if (cmd.clear_box) begin
			for (int a = 0; a < 3; a++) begin
				min_q[a] <= BoxW'(36'sh0FFFFFFFF);
				max_q[a] <= -BoxW'(36'sh100000000);
			end
		end else if (cmd.store) begin
			for (int a = 0; a < 3; a++) begin
				logic signed [BoxW-1:0] rel;
				rel = BoxW'($signed(pt_xyz[a*32 +: 32])) - BoxW'($signed(origin[a*32 +: 32]));
				if (rel < min_q[a]) min_q[a] <= rel;
				if (rel > max_q[a]) max_q[a] <= rel;
			end
		end
	end

	// Restoring dividers, one quotient bit per axis per step.
	always_ff @(posedge clk) begin
		if (cmd.load_pt) begin
			col_q <= rgb_rd;
			for (int a = 0; a < 3; a++) begin
				logic signed [BoxW-1:0] sz, nm;
				sz = max_q[a] - min_q[a];
				nm = BoxW'($signed(xyz_rd[a*32 +: 32])) - BoxW'($signed(origin[a*32 +: 32]))
					- min_q[a];
				size_q[a] <= sz;
				rem_q[a]  <= nm;
				quo_q[a]  <= '0;
				if (sz <= 0 || nm <= 0) mode_q[a] <= ModeZero;
				else if (nm >= sz) mode_q[a] <= ModeMax;
				else mode_q[a] <= ModeDiv;
			end
		end else if (cmd.step) begin
			for (int a = 0; a < 3; a++) begin
				logic [BoxW-1:0] r2;
				r2 = {rem_q[a][BoxW-2:0], 1'b0};
				if (r2 >= size_q[a]) begin
					rem_q[a] <= r2 - size_q[a];
					quo_q[a] <= {quo_q[a][QW-2:0], 1'b1};
				end else begin
					rem_q[a] <= r2;
					quo_q[a] <= {quo_q[a][QW-2:0], 1'b0};
				end
			end
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			case (mode_q[a])
				ModeZero: qf[a*30 +: 30] = '0;
				ModeMax:  qf[a*30 +: 30] = '1;
				default:  qf[a*30 +: 30] = quo_q[a];
			endcase
		end
	end

	// Header layout: box minimum then box maximum, x lowest.
	always_comb begin
		hdr_d = '0;
		for (int a = 0; a < 3; a++) begin
			hdr_d[a*33 +: 33]      = min_q[a][32:0];
			hdr_d[99 + a*33 +: 33] = max_q[a][32:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit_hdr || cmd.emit_pt) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_hdr) begin
			user_q <= {cmd.last, KindHeader};
			data_q <= hdr_d;
		end else if (cmd.emit_pt) begin
			user_q <= {cmd.last, KindPoint};
			data_q <= {8'b0, col_q,
				qf[69:60], qf[39:30], qf[9:0],
				qf[79:70], qf[49:40], qf[19:10],
				qf[89:80], qf[59:50], qf[29:20], 198'b0};
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = user_q;
	assign m_tdata  = data_q;
	assign sts.out_busy = valid_q && !m_tready;

endmodule

// ----- src/bpq_ctrl.sv -----
module bpq_ctrl #(
	parameter int unsigned BatchPoints = 32,
	parameter int unsigned IdxW = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tlast,
	output logic              s_tready,
	input  bpq_pkg::bpq_sts_t sts,
	output bpq_pkg::bpq_cmd_t cmd,
	output logic [IdxW-1:0]   wr_idx,
	output logic [IdxW-1:0]   rd_idx
);
	import bpq_pkg::*;

	typedef enum logic [2:0] {
		S_COLLECT, S_HEADER, S_READ, S_LOAD, S_DIV, S_EMIT
	} state_t;

	state_t        state_q;
	logic [IdxW:0] cnt_q;
	logic [IdxW:0] idx_q;
	logic [4:0]    step_q;
	logic          acc;

	assign s_tready = (state_q == S_COLLECT);
	assign acc      = s_tvalid && s_tready;
	assign wr_idx   = cnt_q[IdxW-1:0];
	assign rd_idx   = idx_q[IdxW-1:0];

	always_comb begin
		cmd = '0;
		cmd.store = acc;
		case (state_q)
			S_HEADER: begin
				cmd.emit_hdr = !sts.out_busy;
				cmd.last     = (cnt_q == '0);
			end
			S_LOAD:   cmd.load_pt = 1'b1;
			S_DIV:    cmd.step = 1'b1;
			S_EMIT: begin
				cmd.emit_pt   = !sts.out_busy;
				cmd.last      = (idx_q + 1'b1 == cnt_q);
				cmd.clear_box = !sts.out_busy && (idx_q + 1'b1 == cnt_q);
			end
			default: ;
		endcase
	end

	// Sequencer: collect, header, then read/load/divide/emit each point.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_COLLECT;
			cnt_q   <= '0;
			idx_q   <= '0;
			step_q  <= '0;
		end else begin
			case (state_q)
				S_COLLECT: if (acc) begin
					cnt_q <= cnt_q + 1'b1;
					if (s_tlast || cnt_q + 1'b1 == (IdxW+1)'(BatchPoints)) begin
						state_q <= S_HEADER;
					end
				end
				S_HEADER: if (!sts.out_busy) begin
					idx_q   <= '0;
					state_q <= S_READ;
				end
				S_READ: state_q <= S_LOAD;
				S_LOAD: begin
					step_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == 5'd29) state_q <= S_EMIT;
				end
				S_EMIT: if (!sts.out_busy) begin
					if (idx_q + 1'b1 == cnt_q) begin
						cnt_q   <= '0;
						state_q <= S_COLLECT;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_READ;
					end
				end
				default: state_q <= S_COLLECT;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (IdxW+1)'(BatchPoints)) else $error("count overflow");
	a_noacc: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_COLLECT |-> !cmd.emit_pt && !cmd.emit_hdr) else $error("emit in collect");
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOAD |=> state_q == S_DIV) else $error("divider start");
`endif

endmodule

// ----- src/batch_point_quantizer_unit.sv -----
// Batch point quantizer. Points are stored (up to BATCH_POINTS) while the
// box relative to the origin registers is tracked; a batch closes on tlast or
// when the store is full. Then one header and one result per point follow.
// Input is taken at one point per cycle while collecting; each point result
// goes through a RAM read, a divider load, 30 steps of the three parallel
// restoring dividers (one quotient bit per cycle) and the emit, which waits
// while the output is stalled. No input is accepted while a batch is emitted.
module batch_point_quantizer_unit #(
	parameter int unsigned BATCH_POINTS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [119:0] s_tdata,  // px, py, pz, red, green, blue
	input  logic         s_tlast,  // batch_end
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [319:0] m_tdata,  // box_min_x..z, box_max_x..z, coarse, middle, fine, color
	output logic [1:0]   m_tuser,  // kind, run_last
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import bpq_pkg::*;

	localparam int unsigned IdxW = (BATCH_POINTS > 1) ? $clog2(BATCH_POINTS) : 1;

	logic [31:0] org_q [3];
	bpq_cmd_t cmd;
	bpq_sts_t sts;
	logic [IdxW-1:0] wr_idx, rd_idx;

	assign pready = 1'b1;

	// Origin registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) org_q[a] <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr)
				RegOriginX: org_q[0] <= pwdata;
				RegOriginY: org_q[1] <= pwdata;
				RegOriginZ: org_q[2] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			RegOriginX: prdata = org_q[0];
			RegOriginY: prdata = org_q[1];
			RegOriginZ: prdata = org_q[2];
			default:    prdata = '0;
		endcase
	end

	bpq_ctrl #(.BatchPoints(BATCH_POINTS), .IdxW(IdxW)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tlast(s_tlast),
		.s_tready(s_tready), .sts(sts), .cmd(cmd), .wr_idx(wr_idx), .rd_idx(rd_idx));

	bpq_datapath #(.BatchPoints(BATCH_POINTS), .IdxW(IdxW)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .wr_idx(wr_idx),
		.rd_idx(rd_idx), .pt_xyz(s_tdata[95:0]), .pt_rgb(s_tdata[119:96]),
		.origin({org_q[2], org_q[1], org_q[0]}), .m_tready(m_tready),
		.m_tvalid(m_tvalid), .m_tuser(m_tuser), .m_tdata(m_tdata));

endmodule
